// ----- src/i2da_pkg.sv -----
`default_nettype none
package i2da_pkg;

  // Field widths
  localparam int VALUE_W = 64;
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 5;
  localparam int CAP_W   = 8;
  localparam int STEP_W  = $clog2(VALUE_W);

  // Defaults and character codes
  localparam int               DEF_MAX_DIGITS = 20;
  localparam logic [CAP_W-1:0]  CAP_RESET      = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_ZERO      = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS     = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'h00;

  typedef struct packed {
    logic [VALUE_W-1:0] value_bits;
    logic               is_signed;
    logic               count_only;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              char_valid;
    logic [LEN_W-1:0]  text_length;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_SIZE,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// ----- src/int64_to_decimal_ascii_top.sv -----
`default_nettype none
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    i2da_pkg::in_item_t
// out_      output     out_valid / out_ready  i2da_pkg::out_item_t
// cfg_      input      cfg_we                 buffer capacity, 8 bits
//
// One item passes through an accept state, 64 shift-add-3 steps of the shared
// BCD adjuster, a leading-zero scan of up to MAX_DIGITS digits, a sizing state,
// then the emission of the result items (1 to 21). Fewer digits mean a longer
// scan but fewer result items.
// in_ready is high only while the sequencer is idle.
// Reset (synchronous, active low) sets capacity to 32 and empties the output.
// A stalled out_ready holds the output register and pauses emission.
module int64_to_decimal_ascii_top #(
  parameter int MAX_DIGITS = i2da_pkg::DEF_MAX_DIGITS
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  i2da_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output i2da_pkg::out_item_t            out_data,
  input  wire                            cfg_we,
  input  wire  [i2da_pkg::CAP_W-1:0]     cfg_wdata
);

  localparam int BW = 4 * MAX_DIGITS;
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int VW = i2da_pkg::VALUE_W;
  localparam int LW = i2da_pkg::LEN_W;
  localparam int CW = i2da_pkg::CAP_W;
  localparam int SW = i2da_pkg::STEP_W;

  i2da_pkg::state_t     state_r, state_nxt;
  logic [VW-1:0]        mag_r, mag_nxt;
  logic [BW-1:0]        bcd_r, bcd_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 neg_r, neg_nxt;
  logic                 cnt_r, cnt_nxt;
  logic [SW-1:0]        step_r, step_nxt;
  logic [IW-1:0]        dptr_r, dptr_nxt;
  logic [LW-1:0]        pos_r, pos_nxt;
  logic [LW-1:0]        keep_r, keep_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic [CW-1:0]        cap_r;
  logic                 out_valid_r, out_valid_nxt;
  i2da_pkg::out_item_t  out_item_r, out_item_nxt;

  logic [BW-1:0]        bcd_adj;
  logic [3:0]           dig [MAX_DIGITS];
  logic                 in_neg;
  logic [CW-1:0]        cap_m1;
  i2da_pkg::out_item_t  item;
  logic                 load;

  // Shared adjuster: add 3 to every digit of 5 or more
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                     : bcd_r[4*i +: 4];
    end
  end

  // Digit view of the BCD register
  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_dig
    assign dig[g] = bcd_r[4*g +: 4];
  end

  assign in_neg  = in_data.is_signed & in_data.value_bits[VW-1];
  assign cap_m1  = cap_r - CW'(1);
  assign load    = (state_r == i2da_pkg::ST_EMIT) && (!out_valid_r || out_ready);

  // Result item at the current emit position
  always_comb begin
    item = '0;
    if (cnt_r) begin
      item.text_length = len_r;
      item.last        = 1'b1;
    end else if (cap_r == '0) begin
      item.last = 1'b1;
    end else if (pos_r == keep_r) begin
      item.out_char    = i2da_pkg::CHAR_NUL;
      item.char_valid  = 1'b1;
      item.text_length = keep_r;
      item.last        = 1'b1;
    end else begin
      item.char_valid = 1'b1;
      if (neg_r && pos_r == '0) begin
        item.out_char = i2da_pkg::CHAR_MINUS;
      end else begin
        item.out_char = i2da_pkg::CHAR_ZERO | {4'd0, dig[dptr_r]};
      end
    end
  end

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    ovf_nxt       = ovf_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    dptr_nxt      = dptr_r;
    pos_nxt       = pos_r;
    keep_nxt      = keep_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      i2da_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          neg_nxt   = in_neg;
          cnt_nxt   = in_data.count_only;
          mag_nxt   = in_neg ? (~in_data.value_bits) + VW'(1) : in_data.value_bits;
          bcd_nxt   = '0;
          ovf_nxt   = 1'b0;
          step_nxt  = '0;
          state_nxt = i2da_pkg::ST_CONV;
        end
      end
      i2da_pkg::ST_CONV: begin
        // one double-dabble step; carry out of the top digit marks truncation
        bcd_nxt  = {bcd_adj[BW-2:0], mag_r[VW-1]};
        ovf_nxt  = ovf_r | bcd_adj[BW-1];
        mag_nxt  = {mag_r[VW-2:0], 1'b0};
        step_nxt = step_r + SW'(1);
        dptr_nxt = IW'(MAX_DIGITS - 1);
        if (step_r == SW'(VW - 1)) begin
          state_nxt = i2da_pkg::ST_SCAN;
        end
      end
      i2da_pkg::ST_SCAN: begin
        // find the most significant nonzero digit, one per cycle
        if (ovf_r || dig[dptr_r] != 4'd0 || dptr_r == '0) begin
          state_nxt = i2da_pkg::ST_SIZE;
        end else begin
          dptr_nxt = dptr_r - IW'(1);
        end
      end
      i2da_pkg::ST_SIZE: begin
        len_nxt  = LW'(dptr_r) + LW'(1) + LW'(neg_r);
        pos_nxt  = '0;
        if (cap_r == '0) begin
          keep_nxt = '0;
        end else if (CW'(LW'(dptr_r) + LW'(1) + LW'(neg_r)) < cap_m1) begin
          keep_nxt = LW'(dptr_r) + LW'(1) + LW'(neg_r);
        end else begin
          keep_nxt = cap_m1[LW-1:0];
        end
        state_nxt = i2da_pkg::ST_EMIT;
      end
      i2da_pkg::ST_EMIT: begin
        if (load) begin
          out_item_nxt  = item;
          out_valid_nxt = 1'b1;
          pos_nxt       = pos_r + LW'(1);
          if (!(neg_r && pos_r == '0)) begin
            dptr_nxt = dptr_r - IW'(1);
          end
          if (item.last) begin
            state_nxt = i2da_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = i2da_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i2da_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cap_r       <= i2da_pkg::CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    ovf_r      <= ovf_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    step_r     <= step_nxt;
    dptr_r     <= dptr_nxt;
    pos_r      <= pos_nxt;
    keep_r     <= keep_nxt;
    len_r      <= len_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
`default_nettype wire

// ----- tb/sv/i2da_text_checker.sv -----
`default_nettype none
// Watches the item and result channels of the decimal text converter, predicts
// the byte run of every accepted item and checks each result against it.
module i2da_text_checker
  import i2da_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  input  wire              in_ready,
  input  in_item_t         in_data,
  input  wire              out_valid,
  input  wire              out_ready,
  input  out_item_t        out_data,
  input  wire              cfg_we,
  input  wire  [CAP_W-1:0] cfg_wdata,
  output int               mismatches,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CAP_W-1:0] capacity;
  out_item_t        expected_chars[$];
  int               results_checked;

  initial begin
    mismatches      = 0;
    pending         = 0;
    results_checked = 0;
    capacity        = CAP_RESET;
  end

  // one line per mismatch, and count it
  task automatic report(string what);
    $display("%0t ns: result %0d: %s", $time, results_checked, what);
    mismatches++;
  endtask

  // expected byte run for one item at the current capacity
  function automatic void predict_text(in_item_t it);
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  text[$];
    bit                 neg;
    int                 keep;
    mag = it.value_bits;
    neg = it.is_signed && mag[VALUE_W-1];
    if (neg) mag = ~mag + 64'd1;
    if (mag == 0) begin
      text.push_front(CHAR_ZERO);
    end else begin
      while (mag != 0 && text.size() < MAX_DIGITS) begin
        text.push_front(CHAR_ZERO + 8'(mag % 10));
        mag = mag / 10;
      end
    end
    if (neg) text.push_front(CHAR_MINUS);

    if (it.count_only) begin
      expected_chars.push_back(out_item_t'{CHAR_NUL, 1'b0, LEN_W'(text.size()), 1'b1});
    end else if (capacity == 0) begin
      // nothing fits, not even the terminator
      expected_chars.push_back(out_item_t'{CHAR_NUL, 1'b0, LEN_W'(0), 1'b1});
    end else begin
      // keep the leading characters that fit beside the NUL
      keep = (text.size() < int'(capacity) - 1) ? text.size() : int'(capacity) - 1;
      for (int i = 0; i < keep; i++) begin
        expected_chars.push_back(out_item_t'{text[i], 1'b1, LEN_W'(0), 1'b0});
      end
      expected_chars.push_back(out_item_t'{CHAR_NUL, 1'b1, LEN_W'(keep), 1'b1});
    end
  endfunction

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_chars.size() == 0) begin
      report($sformatf("result item %h with nothing expected", got));
      return;
    end
    want = expected_chars.pop_front();
    if (got.out_char !== want.out_char)
      report($sformatf("out_char got %02h exp %02h", got.out_char, want.out_char));
    if (got.char_valid !== want.char_valid)
      report($sformatf("char_valid got %b exp %b", got.char_valid, want.char_valid));
    if (got.text_length !== want.text_length)
      report($sformatf("text_length got %0d exp %0d", got.text_length, want.text_length));
    if (got.last !== want.last)
      report($sformatf("last got %b exp %b", got.last, want.last));
    results_checked++;
  endtask

  // sample all three ports at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      capacity = CAP_RESET;
      expected_chars.delete();
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      if (in_valid && in_ready) predict_text(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
    pending = expected_chars.size();
  end

endmodule
`default_nettype wire

// ----- tb/sv/int64_to_decimal_ascii_top_test.sv -----
`default_nettype none
module int64_to_decimal_ascii_top_test;
  import i2da_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  int               mismatches;
  int               pending;
  int               cyc;
  int               results_seen;
  int               hold_left;
  int               next_hold_at;

  int64_to_decimal_ascii_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  i2da_text_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n && out_valid && out_ready) results_seen <= results_seen + 1;
  end

  // long windows with no random stalls on either side
  function automatic bit quiet();
    return (cyc % 8000) >= 5500;
  endfunction

  // receiver: random stalls, plus a long hold-off now and then to back up the block
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left  = hold_left - 1;
    end else if (rst_n && results_seen >= next_hold_at) begin
      out_ready    <= 1'b0;
      hold_left     = 400;
      next_hold_at  = next_hold_at + 900;
    end else if (!quiet() && $urandom_range(0, 99) < 20) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [VALUE_W-1:0] pow10(int k);
    logic [VALUE_W-1:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  function automatic in_item_t mk(logic [VALUE_W-1:0] v, bit sgn, bit cnt);
    in_item_t it;
    it.value_bits = v;
    it.is_signed  = sgn;
    it.count_only = cnt;
    return it;
  endfunction

  // values weighted toward digit-count boundaries and the sign extremes
  function automatic in_item_t rand_item();
    logic [VALUE_W-1:0] v;
    int                 off;
    off = int'($urandom_range(0, 2)) - 1;
    case ($urandom_range(0, 7))
      0: v = 64'($urandom_range(0, 20));
      1: v = ~64'($urandom_range(0, 20)) + 64'd1;
      2: v = pow10($urandom_range(0, 19)) + 64'(off);
      3: v = {1'b1, 63'd0} + 64'($urandom_range(0, 3));
      4: v = {1'b0, {63{1'b1}}} - 64'($urandom_range(0, 3));
      5: v = {64{1'b1}} - 64'($urandom_range(0, 3));
      6: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: v = {$urandom, $urandom};
    endcase
    return mk(v, 1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0);
  endfunction

  // offer one item; returns at the falling edge after it is taken
  task automatic send_item(in_item_t it);
    while (!quiet() && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // drain every expected result, then write the capacity while idle
  task automatic set_capacity(logic [CAP_W-1:0] c);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [CAP_W-1:0] c;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    cyc          = 0;
    results_seen = 0;
    hold_left    = 0;
    next_hold_at = 300;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, at the reset capacity
    send_item(mk(64'd0, 1'b0, 1'b0));
    send_item(mk(64'd0, 1'b1, 1'b0));
    send_item(mk(64'd1, 1'b0, 1'b0));
    send_item(mk(64'd9, 1'b1, 1'b0));
    send_item(mk(64'd10, 1'b0, 1'b0));
    send_item(mk(64'd99, 1'b1, 1'b0));
    send_item(mk(64'd100, 1'b0, 1'b0));
    send_item(mk({64{1'b1}}, 1'b0, 1'b0));
    send_item(mk({64{1'b1}}, 1'b1, 1'b0));
    send_item(mk({1'b1, 63'd0}, 1'b1, 1'b0));
    send_item(mk({1'b1, 63'd0}, 1'b0, 1'b0));
    send_item(mk({1'b0, {63{1'b1}}}, 1'b1, 1'b0));
    send_item(mk(pow10(19) - 1, 1'b0, 1'b0));
    send_item(mk(pow10(19), 1'b0, 1'b0));
    send_item(mk(pow10(19), 1'b1, 1'b0));
    send_item(mk(~64'd10 + 64'd1, 1'b1, 1'b0));
    send_item(mk({64{1'b1}}, 1'b0, 1'b1));
    send_item(mk({1'b1, 63'd0}, 1'b1, 1'b1));
    send_item(mk(64'd0, 1'b0, 1'b1));
    send_item(mk({64{1'b1}}, 1'b1, 1'b1));
    send_item(mk({32{2'b10}}, 1'b0, 1'b0));
    send_item(mk({32{2'b01}}, 1'b1, 1'b0));

    // random items over a sweep of capacities, zero and full among them
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: c = 8'd0;
        1: c = 8'd1;
        2: c = 8'd2;
        3: c = 8'd255;
        4: c = 8'd5;
        5: c = 8'd12;
        6: c = 8'd20;
        7: c = 8'd21;
        8: c = 8'($urandom_range(3, 19));
        default: c = 8'd128;
      endcase
      set_capacity(c);
      repeat (16) send_item(rand_item());
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
src/i2da_pkg.sv
src/int64_to_decimal_ascii_top.sv
tb/sv/i2da_text_checker.sv
tb/sv/int64_to_decimal_ascii_top_test.sv
